>>> design/aaid_pkg.sv
`default_nettype none
package aaid_pkg;

    localparam int MAX_SRC_DIM = 4096;
    localparam int MAX_DST_W   = 64;
    localparam int MAX_DST_H   = 32;

    localparam int SUM_W   = 40;
    localparam int CNT_W   = 24;
    localparam int ACC_W   = 3 * SUM_W + CNT_W;
    localparam int COL_W   = 6;
    localparam int SHORT_W = 20;
    localparam int DIV_CNT_W = 6;

    // divider operand selection
    localparam logic [1:0] OP_COL = 2'd0;
    localparam logic [1:0] OP_ROW = 2'd1;
    localparam logic [1:0] OP_SUM = 2'd2;

    // colour channels
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_SRC_W = 2'd0;
    localparam logic [1:0] REG_SRC_H = 2'd1;
    localparam logic [1:0] REG_DST_W = 2'd2;
    localparam logic [1:0] REG_DST_H = 2'd3;

    typedef struct packed {
        logic       take;
        logic       div_start;
        logic [1:0] div_op;
        logic       col_ld;
        logic       row_ld;
        logic       acc;
        logic       rt_start;
        logic       avg_ld;
        logic       out_ld;
        logic [1:0] chan;
    } t_cmd;

    typedef struct packed {
        logic cfg_ok;
        logic emit;
        logic div_done;
        logic rt_done;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

>>> design/area_average_image_downscaler.sv
// each pixel runs two 20-step bounds divides, column then row, then accumulates
// a pixel closing a region then runs three 40-step divides of the squared sums by the
// count, each with a rounded root, then loads the output register when it is free
// input is ready again only once the last pixel is through; an unread result
// stalls only a pixel that closes another region, until the output register is free
// reset: synchronous active low, settings return to 1 and the frame restarts
`default_nettype none
module area_average_image_downscaler (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // source pixel channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_red,
    input  wire logic [7:0]  i_green,
    input  wire logic [7:0]  i_blue,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_avg_red,
    output logic [7:0]       o_avg_green,
    output logic [7:0]       o_avg_blue,
    output logic [5:0]       o_cell_x,
    output logic [4:0]       o_cell_y,
    output logic             o_bottom_half,
    output logic             o_frame_last,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [12:0] i_cfg_data
);
    import aaid_pkg::*;

    // commands from the sequencer, status back from the datapath
    t_cmd    cmd;
    t_status status;

    // controller: bounds and accumulate for each pixel, root when a region closes
    aaid_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath: settings, position, per-column accumulators, divider, root
    aaid_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_avg_red     (o_avg_red),
        .o_avg_green   (o_avg_green),
        .o_avg_blue    (o_avg_blue),
        .o_cell_x      (o_cell_x),
        .o_cell_y      (o_cell_y),
        .o_bottom_half (o_bottom_half),
        .o_frame_last  (o_frame_last)
    );
endmodule
`default_nettype wire

>>> design/aaid_ram.sv
`default_nettype none
module aaid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

>>> design/aaid_div.sv
`default_nettype none
module aaid_div (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [aaid_pkg::SUM_W-1:0]       i_num,
    input  wire logic [aaid_pkg::CNT_W-1:0]       i_den,
    input  wire logic [aaid_pkg::DIV_CNT_W-1:0]   i_steps,
    output logic      [aaid_pkg::SUM_W-1:0]       o_quo,
    output logic                                  o_done
);
    import aaid_pkg::*;

    logic [SUM_W-1:0]     r_num;
    logic [CNT_W-1:0]     r_rem;
    logic [CNT_W-1:0]     r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W:0]       rem_sh;
    logic [CNT_W:0]       diff;
    logic                 ge;

    // one quotient bit per cycle, restoring
    assign rem_sh = {r_rem, r_num[SUM_W-1]};
    assign diff   = rem_sh - {1'b0, r_den};
    assign ge     = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_num  <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
            r_cnt  <= i_steps;
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_num <= {r_num[SUM_W-2:0], ge};
            r_rem <= ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_quo  = r_num;
    assign o_done = r_done;
endmodule
`default_nettype wire

>>> design/aaid_ctrl.sv
`default_nettype none
module aaid_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire aaid_pkg::t_status i_status,
    output aaid_pkg::t_cmd         o_cmd
);
    import aaid_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_COL_GO   = 4'd1;
    localparam logic [3:0] S_COL_WAIT = 4'd2;
    localparam logic [3:0] S_ROW_GO   = 4'd3;
    localparam logic [3:0] S_ROW_WAIT = 4'd4;
    localparam logic [3:0] S_ACC      = 4'd5;
    localparam logic [3:0] S_Q_GO     = 4'd6;
    localparam logic [3:0] S_Q_WAIT   = 4'd7;
    localparam logic [3:0] S_RT_GO    = 4'd8;
    localparam logic [3:0] S_RT_WAIT  = 4'd9;
    localparam logic [3:0] S_OUT      = 4'd10;

    logic [3:0] r_state, n_state;
    logic [1:0] r_chan, n_chan;

    always_comb begin
        n_state    = r_state;
        n_chan     = r_chan;
        o_cmd      = '0;
        o_cmd.chan = r_chan;
        o_in_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                o_cmd.take = i_in_valid;
                if (i_in_valid && i_status.cfg_ok) begin
                    n_state = S_COL_GO;
                end
            end
            S_COL_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = OP_COL;
                n_state         = S_COL_WAIT;
            end
            S_COL_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.col_ld = 1'b1;
                    n_state      = S_ROW_GO;
                end
            end
            S_ROW_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = OP_ROW;
                n_state         = S_ROW_WAIT;
            end
            S_ROW_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.row_ld = 1'b1;
                    n_state      = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (i_status.emit) begin
                    n_chan  = CH_RED;
                    n_state = S_Q_GO;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_Q_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = OP_SUM;
                n_state         = S_Q_WAIT;
            end
            S_Q_WAIT: begin
                if (i_status.div_done) begin
                    n_state = S_RT_GO;
                end
            end
            S_RT_GO: begin
                o_cmd.rt_start = 1'b1;
                n_state        = S_RT_WAIT;
            end
            S_RT_WAIT: begin
                if (i_status.rt_done) begin
                    o_cmd.avg_ld = 1'b1;
                    if (r_chan == CH_BLUE) begin
                        n_state = S_OUT;
                    end else begin
                        n_chan  = r_chan + 2'd1;
                        n_state = S_Q_GO;
                    end
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_chan  <= CH_RED;
        end else begin
            r_state <= n_state;
            r_chan  <= n_chan;
        end
    end
endmodule
`default_nettype wire

>>> design/aaid_dp.sv
`default_nettype none
module aaid_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire aaid_pkg::t_cmd    i_cmd,
    output aaid_pkg::t_status      o_status,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [12:0]       i_cfg_data,
    input  wire logic [7:0]        i_red,
    input  wire logic [7:0]        i_green,
    input  wire logic [7:0]        i_blue,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [7:0]             o_avg_red,
    output logic [7:0]             o_avg_green,
    output logic [7:0]             o_avg_blue,
    output logic [5:0]             o_cell_x,
    output logic [4:0]             o_cell_y,
    output logic                   o_bottom_half,
    output logic                   o_frame_last
);
    import aaid_pkg::*;

    logic [12:0] r_src_w, r_src_h;
    logic [6:0]  r_dst_w;
    logic [5:0]  r_dst_h;
    logic [11:0] r_src_col, r_src_row;
    logic [COL_W-1:0] r_cell_col;
    logic [5:0]  r_sub_row;
    logic [MAX_DST_W-1:0] r_vld;

    logic [15:0] r_sq_r, r_sq_g, r_sq_b;
    logic [COL_W-1:0] r_c;
    logic        r_hit;
    logic [12:0] r_col_end, r_row_end;

    logic [SUM_W-1:0] r_sum_r, r_sum_g, r_sum_b;
    logic [CNT_W-1:0] r_cnt;
    logic [COL_W-1:0] r_e_cx;
    logic [5:0]  r_e_sub;
    logic        r_e_last;
    logic [7:0]  r_avg_r, r_avg_g, r_avg_b;

    logic [16:0] r_rt_q;
    logic [8:0]  r_rt_root, r_rt_bit;
    logic        r_rt_busy, r_rt_done;

    logic        cfg_we, cfg_ok;
    logic [COL_W-1:0] c_now;
    logic [ACC_W-1:0] rdata, old;
    logic [SUM_W-1:0] n_sum_r, n_sum_g, n_sum_b;
    logic [CNT_W-1:0] n_cnt;
    logic [12:0] col_p1, row_p1;
    logic        col_done, row_done, emit;
    logic [SHORT_W-1:0] col_num, row_num;
    logic [SUM_W-1:0] div_num, div_quo;
    logic [CNT_W-1:0] div_den;
    logic [DIV_CNT_W-1:0] div_steps;
    logic        div_done;
    logic [SUM_W-1:0] sum_sel;
    logic [8:0]  rt_try;
    logic [17:0] rt_try_sq, rt_sq, rt_diff;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;

    assign cfg_ok = (r_src_w >= 13'd1) && (r_src_w <= 13'(MAX_SRC_DIM))
                 && (r_src_h >= 13'd1) && (r_src_h <= 13'(MAX_SRC_DIM))
                 && (r_dst_w >= 7'd1) && (r_dst_w <= 7'(MAX_DST_W))
                 && (13'(r_dst_w) <= r_src_w)
                 && (r_dst_h >= 6'd1) && (r_dst_h <= 6'(MAX_DST_H))
                 && (13'({r_dst_h, 1'b0}) <= r_src_h);

    assign c_now = ({1'b0, r_cell_col} >= r_dst_w) ? COL_W'(r_dst_w - 7'd1) : r_cell_col;

    aaid_ram #(.WIDTH(ACC_W), .DEPTH(MAX_DST_W)) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.acc && !emit),
        .i_waddr (r_c),
        .i_wdata ({n_sum_r, n_sum_g, n_sum_b, n_cnt}),
        .i_re    (i_cmd.take),
        .i_raddr (c_now),
        .o_rdata (rdata)
    );

    // an entry never written since the frame began reads as zero
    assign old     = r_hit ? rdata : '0;
    assign n_sum_r = old[ACC_W-1 -: SUM_W] + SUM_W'(r_sq_r);
    assign n_sum_g = old[ACC_W-1-SUM_W -: SUM_W] + SUM_W'(r_sq_g);
    assign n_sum_b = old[ACC_W-1-2*SUM_W -: SUM_W] + SUM_W'(r_sq_b);
    assign n_cnt   = old[CNT_W-1:0] + CNT_W'(1);

    assign col_p1   = {1'b0, r_src_col} + 13'd1;
    assign row_p1   = {1'b0, r_src_row} + 13'd1;
    assign col_done = (col_p1 >= r_col_end);
    assign row_done = (row_p1 >= r_row_end);
    assign emit     = col_done && row_done;

    assign col_num = SHORT_W'({1'b0, r_c} + 7'd1) * SHORT_W'(r_src_w);
    assign row_num = SHORT_W'({1'b0, r_sub_row} + 7'd1) * SHORT_W'(r_src_h);

    always_comb begin
        unique case (i_cmd.chan)
            CH_RED:   sum_sel = r_sum_r;
            CH_GREEN: sum_sel = r_sum_g;
            default:  sum_sel = r_sum_b;
        endcase
    end

    always_comb begin
        unique case (i_cmd.div_op)
            OP_COL: begin
                div_num   = {col_num, (SUM_W-SHORT_W)'(0)};
                div_den   = CNT_W'(r_dst_w);
                div_steps = DIV_CNT_W'(SHORT_W);
            end
            OP_ROW: begin
                div_num   = {row_num, (SUM_W-SHORT_W)'(0)};
                div_den   = CNT_W'({r_dst_h, 1'b0});
                div_steps = DIV_CNT_W'(SHORT_W);
            end
            OP_SUM: begin
                div_num   = sum_sel;
                div_den   = (r_cnt == '0) ? CNT_W'(1) : r_cnt;
                div_steps = DIV_CNT_W'(SUM_W);
            end
            default: begin
                div_num   = '0;
                div_den   = CNT_W'(1);
                div_steps = DIV_CNT_W'(1);
            end
        endcase
    end

    aaid_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_steps (div_steps),
        .o_quo   (div_quo),
        .o_done  (div_done)
    );

    // configuration and frame position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w    <= 13'd1;
            r_src_h    <= 13'd1;
            r_dst_w    <= 7'd1;
            r_dst_h    <= 6'd1;
            r_src_col  <= '0;
            r_src_row  <= '0;
            r_cell_col <= '0;
            r_sub_row  <= '0;
            r_vld      <= '0;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                REG_SRC_W: r_src_w <= i_cfg_data;
                REG_SRC_H: r_src_h <= i_cfg_data;
                REG_DST_W: r_dst_w <= i_cfg_data[6:0];
                REG_DST_H: r_dst_h <= i_cfg_data[5:0];
                default:   r_dst_h <= i_cfg_data[5:0];
            endcase
            r_src_col  <= '0;
            r_src_row  <= '0;
            r_cell_col <= '0;
            r_sub_row  <= '0;
            r_vld      <= '0;
        end else if (i_cmd.acc) begin
            r_vld[r_c] <= !emit;
            if (col_p1 >= r_src_w) begin
                r_src_col  <= '0;
                r_cell_col <= '0;
                if (row_p1 >= r_src_h) begin
                    r_src_row <= '0;
                    r_sub_row <= '0;
                end else begin
                    r_src_row <= row_p1[11:0];
                    if (row_done) begin
                        r_sub_row <= r_sub_row + 6'd1;
                    end
                end
            end else begin
                r_src_col  <= col_p1[11:0];
                r_cell_col <= col_done ? r_c + COL_W'(1) : r_c;
            end
        end
    end

    // item payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_sq_r <= 16'(i_red) * 16'(i_red);
            r_sq_g <= 16'(i_green) * 16'(i_green);
            r_sq_b <= 16'(i_blue) * 16'(i_blue);
            r_c    <= c_now;
            r_hit  <= r_vld[c_now];
        end
        if (i_cmd.col_ld) begin
            r_col_end <= div_quo[12:0];
        end
        if (i_cmd.row_ld) begin
            r_row_end <= div_quo[12:0];
        end
        if (i_cmd.acc) begin
            r_sum_r  <= n_sum_r;
            r_sum_g  <= n_sum_g;
            r_sum_b  <= n_sum_b;
            r_cnt    <= n_cnt;
            r_e_cx   <= r_c;
            r_e_sub  <= r_sub_row;
            r_e_last <= ({1'b0, r_c} + 7'd1 == r_dst_w)
                     && ({1'b0, r_sub_row} + 7'd1 == {r_dst_h, 1'b0});
        end
        if (i_cmd.avg_ld) begin
            unique case (i_cmd.chan)
                CH_RED:   r_avg_r <= r_rt_root[7:0];
                CH_GREEN: r_avg_g <= r_rt_root[7:0];
                default:  r_avg_b <= r_rt_root[7:0];
            endcase
        end
    end

    // rounded root: one result bit per cycle, then the rounding step
    assign rt_try    = r_rt_root | r_rt_bit;
    assign rt_try_sq = 18'(rt_try) * 18'(rt_try);
    assign rt_sq     = 18'(r_rt_root) * 18'(r_rt_root);
    assign rt_diff   = {1'b0, r_rt_q} - rt_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rt_busy <= 1'b0;
            r_rt_done <= 1'b0;
        end else if (i_cmd.rt_start) begin
            r_rt_q    <= (div_quo > SUM_W'(65025)) ? 17'd65025 : div_quo[16:0];
            r_rt_root <= '0;
            r_rt_bit  <= 9'h100;
            r_rt_busy <= 1'b1;
            r_rt_done <= 1'b0;
        end else if (r_rt_busy) begin
            if (r_rt_bit != '0) begin
                if (rt_try_sq <= {1'b0, r_rt_q}) begin
                    r_rt_root <= rt_try;
                end
                r_rt_bit <= r_rt_bit >> 1;
            end else begin
                if (rt_diff > 18'(r_rt_root)) begin
                    r_rt_root <= r_rt_root + 9'd1;
                end
                r_rt_busy <= 1'b0;
                r_rt_done <= 1'b1;
            end
        end else begin
            r_rt_done <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            o_avg_red     <= r_avg_r;
            o_avg_green   <= r_avg_g;
            o_avg_blue    <= r_avg_b;
            o_cell_x      <= r_e_cx;
            o_cell_y      <= r_e_sub[5:1];
            o_bottom_half <= r_e_sub[0];
            o_frame_last  <= r_e_last;
        end
    end

    assign o_status.cfg_ok   = cfg_ok;
    assign o_status.emit     = emit;
    assign o_status.div_done = div_done;
    assign o_status.rt_done  = r_rt_done;
    assign o_status.out_free = !o_out_valid || i_out_ready;
endmodule
`default_nettype wire

>>> tb/tb_area_average_image_downscaler.sv
`default_nettype none
module tb_area_average_image_downscaler;
    import aaid_pkg::*;

    // generous cap, several times the slowest legal run
    localparam int CYCLE_LIMIT = 3000000;
    // settle time before a register write, beyond the longest pixel latency
    localparam int SETTLE_CYCLES = 250;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [5:0] cell_x;
        logic [4:0] cell_y;
        logic       bottom_half;
        logic       frame_last;
    } t_cell_result;

    // area-average predictor plus the queue of cell results still owed
    class downscale_scoreboard;
        int unsigned  src_w, src_h, dst_w, dst_h;
        int unsigned  col, row, cell_col, sub_row;
        logic [39:0]  sq_red [MAX_DST_W];
        logic [39:0]  sq_green [MAX_DST_W];
        logic [39:0]  sq_blue [MAX_DST_W];
        logic [23:0]  px_count [MAX_DST_W];
        t_cell_result owed [$];
        int           mismatches;
        int           cells_seen;
        int           pixels_used;
        int           pixels_ignored;

        function new();
            src_w = 1;
            src_h = 1;
            dst_w = 1;
            dst_h = 1;
            mismatches = 0;
            cells_seen = 0;
            pixels_used = 0;
            pixels_ignored = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            col = 0;
            row = 0;
            cell_col = 0;
            sub_row = 0;
            for (int i = 0; i < MAX_DST_W; i++) begin
                sq_red[i] = '0;
                sq_green[i] = '0;
                sq_blue[i] = '0;
                px_count[i] = '0;
            end
        endfunction

        function bit geometry_ok();
            if (src_w < 1 || src_w > MAX_SRC_DIM) return 0;
            if (src_h < 1 || src_h > MAX_SRC_DIM) return 0;
            if (dst_w < 1 || dst_w > MAX_DST_W || dst_w > src_w) return 0;
            if (dst_h < 1 || dst_h > MAX_DST_H) return 0;
            if (2 * dst_h > src_h) return 0;
            return 1;
        endfunction

        // any register write restarts the frame
        function void write_reg(logic [1:0] idx, logic [12:0] data);
            case (idx)
                REG_SRC_W: src_w = data;
                REG_SRC_H: src_h = data;
                REG_DST_W: dst_w = data[6:0];
                REG_DST_H: dst_h = data[5:0];
                default: ;
            endcase
            restart_frame();
        endfunction

        // nearest integer square root
        function logic [7:0] round_root(longint unsigned q);
            longint unsigned r;
            longint unsigned t;
            r = 0;
            for (longint unsigned b = 256; b != 0; b = b >> 1) begin
                t = r + b;
                if (t * t <= q) r = t;
            end
            if (q - r * r > r) r++;
            return r[7:0];
        endfunction

        function logic [7:0] mean_level(logic [39:0] sum, logic [23:0] cnt);
            longint unsigned q;
            longint unsigned n;
            n = (cnt == 0) ? 1 : cnt;
            q = longint'(sum) / n;
            if (q > 65025) q = 65025;
            return round_root(q);
        endfunction

        function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            int unsigned  c;
            int unsigned  col_end;
            int unsigned  row_end;
            bit           col_done;
            bit           row_done;
            t_cell_result res;
            if (!geometry_ok()) begin
                pixels_ignored++;
                return;
            end
            pixels_used++;
            c = cell_col;
            if (c >= dst_w) c = dst_w - 1;
            sq_red[c]   = sq_red[c] + r * r;
            sq_green[c] = sq_green[c] + g * g;
            sq_blue[c]  = sq_blue[c] + b * b;
            px_count[c] = px_count[c] + 24'd1;
            col_end  = (c + 1) * src_w / dst_w;
            row_end  = (sub_row + 1) * src_h / (2 * dst_h);
            col_done = (col + 1 >= col_end);
            row_done = (row + 1 >= row_end);
            if (col_done && row_done) begin
                res.red         = mean_level(sq_red[c], px_count[c]);
                res.green       = mean_level(sq_green[c], px_count[c]);
                res.blue        = mean_level(sq_blue[c], px_count[c]);
                res.cell_x      = c[5:0];
                res.cell_y      = sub_row[5:1];
                res.bottom_half = sub_row[0];
                res.frame_last  = (c + 1 == dst_w) && (sub_row + 1 == 2 * dst_h);
                owed = {owed, res};
                sq_red[c] = '0;
                sq_green[c] = '0;
                sq_blue[c] = '0;
                px_count[c] = '0;
            end
            col++;
            if (col_done) c++;
            if (col >= src_w) begin
                col = 0;
                c = 0;
                row++;
                if (row_done) sub_row++;
                if (row >= src_h) begin
                    row = 0;
                    sub_row = 0;
                end
            end
            cell_col = c;
        endfunction

        function void check_result(t_cell_result got);
            t_cell_result want;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected cell result x=%0d y=%0d", got.cell_x, got.cell_y);
                return;
            end
            want = owed.pop_front();
            cells_seen++;
            if (got != want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("cell mismatch: exp rgb %0d %0d %0d x%0d y%0d h%0d l%0d, got rgb %0d %0d %0d x%0d y%0d h%0d l%0d",
                             want.red, want.green, want.blue, want.cell_x, want.cell_y,
                             want.bottom_half, want.frame_last,
                             got.red, got.green, got.blue, got.cell_x, got.cell_y,
                             got.bottom_half, got.frame_last);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_red;
    logic [7:0]  i_green;
    logic [7:0]  i_blue;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_avg_red;
    logic [7:0]  o_avg_green;
    logic [7:0]  o_avg_blue;
    logic [5:0]  o_cell_x;
    logic [4:0]  o_cell_y;
    logic        o_bottom_half;
    logic        o_frame_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [12:0] i_cfg_data;

    area_average_image_downscaler u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_avg_red     (o_avg_red),
        .o_avg_green   (o_avg_green),
        .o_avg_blue    (o_avg_blue),
        .o_cell_x      (o_cell_x),
        .o_cell_y      (o_cell_y),
        .o_bottom_half (o_bottom_half),
        .o_frame_last  (o_frame_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    downscale_scoreboard sb = new();
    int unsigned cycles;
    int          burst_left;
    int          stall_mode;
    int          stall_run;
    int          phases;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // accepted transfers on the pixel and register channels feed the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            sb.note_pixel(i_red, i_green, i_blue);
        if (i_rst_n && i_cfg_valid && o_cfg_ready)
            sb.write_reg(i_cfg_index, i_cfg_data);
    end

    // result side: check each transfer, ready follows a changing stall pattern
    always @(posedge i_clk) begin
        t_cell_result got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.red         = o_avg_red;
            got.green       = o_avg_green;
            got.blue        = o_avg_blue;
            got.cell_x      = o_cell_x;
            got.cell_y      = o_cell_y;
            got.bottom_half = o_bottom_half;
            got.frame_last  = o_frame_last;
            sb.check_result(got);
        end
        if (stall_run == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_run  <= $urandom_range(200, 900);
        end else begin
            stall_run <= stall_run - 1;
        end
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= 1'($urandom_range(0, 1));
            default: i_out_ready <= (cycles % 29) > 17;
        endcase
    end

    task automatic write_reg(input logic [1:0] idx, input logic [12:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // pixels in bursts with random gaps; zero and full scale turn up often
    task automatic stream_pixels(input int n);
        int pick;
        for (int i = 0; i < n; i++) begin
            if (burst_left <= 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                burst_left = $urandom_range(1, 40);
            end
            // hold off until every owed cell has come out
            if ($urandom_range(0, 150) == 0) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (sb.owed.size() != 0) @(posedge i_clk);
            end
            pick = $urandom_range(0, 7);
            i_in_valid <= 1'b1;
            i_red   <= (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom);
            i_green <= (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom);
            i_blue  <= (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom);
            do @(posedge i_clk); while (!o_in_ready);
            burst_left--;
        end
        i_in_valid <= 1'b0;
    endtask

    // one setting: all four registers in a rotated order, then pixels, then drain
    task automatic run_geometry(input int sw, input int sh, input int dw, input int dh,
                                input int n);
        logic [12:0] vals [4];
        int          first;
        vals[REG_SRC_W] = 13'(sw);
        vals[REG_SRC_H] = 13'(sh);
        vals[REG_DST_W] = 13'(dw);
        vals[REG_DST_H] = 13'(dh);
        first = $urandom_range(0, 3);
        for (int k = 0; k < 4; k++)
            write_reg(2'(first + k), vals[2'(first + k)]);
        phases++;
        stream_pixels(n);
        wait_drained();
    endtask

    initial begin
        int sw, sh, dw, dh, frame_px, bad;
        cycles      = 0;
        burst_left  = 0;
        stall_mode  = 0;
        stall_run   = 0;
        phases      = 0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_red       <= '0;
        i_green     <= '0;
        i_blue      <= '0;
        i_out_ready <= 1'b1;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_SRC_W;
        i_cfg_data  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        // reset geometry is 1x1 into one cell of two sub-rows: pixels ignored
        stream_pixels(4);
        wait_drained();
        // directed geometries
        run_geometry(2, 2, 1, 1, 8);
        run_geometry(3, 5, 2, 2, 15);
        run_geometry(1, 64, 1, 32, 64);
        run_geometry(64, 64, 64, 32, 140);
        run_geometry(4096, 2, 64, 1, 200);
        run_geometry(4096, 4096, 1, 1, 20);
        run_geometry(5, 4, 6, 1, 6);

        // random geometries, mostly small frames; now and then an illegal one
        while (sb.pixels_used < 1900 || sb.cells_seen < 48) begin
            if ($urandom_range(0, 9) == 0) begin
                bad = $urandom_range(0, 5);
                sw = (bad == 0) ? 0 : (bad == 1) ? $urandom_range(4097, 8191) : 8;
                sh = (bad == 2) ? 3 : 8;
                dw = (bad == 3) ? $urandom_range(65, 127) : (bad == 4) ? 0 : 2;
                dh = (bad == 2) ? 2 : (bad == 5) ? $urandom_range(33, 63) : 1;
                run_geometry(sw, sh, dw, dh, $urandom_range(3, 10));
            end else begin
                sw = $urandom_range(1, 12);
                sh = $urandom_range(2, 12);
                dw = $urandom_range(1, sw);
                dh = $urandom_range(1, sh / 2);
                frame_px = sw * sh;
                run_geometry(sw, sh, dw, dh,
                             frame_px * $urandom_range(1, 2) + $urandom_range(0, frame_px - 1));
            end
        end

        $display("covered %0d geometries, %0d pixels used, %0d pixels ignored",
                 phases, sb.pixels_used, sb.pixels_ignored);
        $display("%0d cells checked, %0d mismatches", sb.cells_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.owed.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire

>>> filelist.f
design/aaid_pkg.sv
design/aaid_ram.sv
design/aaid_div.sv
design/aaid_ctrl.sv
design/aaid_dp.sv
design/area_average_image_downscaler.sv
tb/tb_area_average_image_downscaler.sv
